FILE: rtl/hsvrgb_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared defaults and the hue sector code used across the pipeline.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

  // Default fixed-point width of hue fraction, saturation and value
  localparam int FRAC_BITS_DEF    = 16;
  // Default width of one output color channel
  localparam int CHANNEL_BITS_DEF = 8;

  // One sixth of the hue circle, named by the colors at its two ends
  typedef enum logic [2:0] {
    SEC_R_Y = 3'd0,
    SEC_Y_G = 3'd1,
    SEC_G_C = 3'd2,
    SEC_C_B = 3'd3,
    SEC_B_M = 3'd4,
    SEC_M_R = 3'd5
  } sector_t;

endpackage

FILE: rtl/hsvrgb_prep.sv
// ----------------------------------------------------------------------------
// HSV to RGB input stage
// Clamps saturation and value, splits hue*6 into sector and fraction,
// and scales value by the full channel code.
// ----------------------------------------------------------------------------
module hsvrgb_prep #(
  parameter int FRAC_BITS    = hsvrgb_pkg::FRAC_BITS_DEF,
  parameter int CHANNEL_BITS = hsvrgb_pkg::CHANNEL_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [FRAC_BITS-1:0]              hue,
  input  logic [FRAC_BITS:0]                saturation,
  input  logic [FRAC_BITS:0]                brightness,
  output logic                              valid,
  output logic [FRAC_BITS:0]                sat,
  output logic [FRAC_BITS-1:0]              frac,
  output hsvrgb_pkg::sector_t               sector,
  output logic [FRAC_BITS+CHANNEL_BITS-1:0] vscale
);
  import hsvrgb_pkg::*;

  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [FRAC_BITS:0]                s_clamp;
  logic [FRAC_BITS:0]                v_clamp;
  logic [FRAC_BITS+2:0]              hue_x6;
  logic [FRAC_BITS+CHANNEL_BITS:0]   v_ext;
  logic [FRAC_BITS+CHANNEL_BITS:0]   v_cmax;

  // Values above one saturate to one
  assign s_clamp = (saturation > ONE) ? ONE : saturation;
  assign v_clamp = (brightness > ONE) ? ONE : brightness;

  // hue * 6 as (hue << 2) + (hue << 1)
  assign hue_x6 = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};

  // v * (2^C - 1) as (v << C) - v
  assign v_ext  = {{CHANNEL_BITS{1'b0}}, v_clamp};
  assign v_cmax = (v_ext << CHANNEL_BITS) - v_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    sat    <= s_clamp;
    frac   <= hue_x6[FRAC_BITS-1:0];
    sector <= sector_t'(hue_x6[FRAC_BITS+2:FRAC_BITS]);
    vscale <= v_cmax[FRAC_BITS+CHANNEL_BITS-1:0];
  end

endmodule

FILE: rtl/hsvrgb_weight.sv
// ----------------------------------------------------------------------------
// HSV to RGB weight stage
// Forms the p, q and t weights at scale 2^(2*FRAC_BITS).
// ----------------------------------------------------------------------------
module hsvrgb_weight #(
  parameter int FRAC_BITS    = hsvrgb_pkg::FRAC_BITS_DEF,
  parameter int CHANNEL_BITS = hsvrgb_pkg::CHANNEL_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [FRAC_BITS:0]                sat,
  input  logic [FRAC_BITS-1:0]              frac,
  input  hsvrgb_pkg::sector_t               in_sector,
  input  logic [FRAC_BITS+CHANNEL_BITS-1:0] in_vscale,
  output logic                              valid,
  output hsvrgb_pkg::sector_t               sector,
  output logic [FRAC_BITS+CHANNEL_BITS-1:0] vscale,
  output logic [2*FRAC_BITS:0]              wp,
  output logic [2*FRAC_BITS:0]              wq,
  output logic [2*FRAC_BITS:0]              wt
);
  import hsvrgb_pkg::*;

  localparam logic [FRAC_BITS:0]   ONE   = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [2*FRAC_BITS:0] W_ONE = {1'b1, {(2*FRAC_BITS){1'b0}}};

  logic [FRAC_BITS:0]     one_minus_f;
  logic [FRAC_BITS:0]     one_minus_s;
  logic [2*FRAC_BITS:0]   s_f;
  logic [2*FRAC_BITS+1:0] s_g;

  assign one_minus_f = ONE - {1'b0, frac};
  assign one_minus_s = ONE - sat;
  assign s_f         = {{FRAC_BITS{1'b0}}, sat} * {{(FRAC_BITS+1){1'b0}}, frac};
  assign s_g         = {{(FRAC_BITS+1){1'b0}}, sat} * {{(FRAC_BITS+1){1'b0}}, one_minus_f};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
  end

  // s*(1-f) never exceeds one, so its top bit is dropped
  always_ff @(posedge clk) begin
    sector <= in_sector;
    vscale <= in_vscale;
    wp     <= {one_minus_s, {FRAC_BITS{1'b0}}};
    wq     <= W_ONE - s_f;
    wt     <= W_ONE - s_g[2*FRAC_BITS:0];
  end

endmodule

FILE: rtl/hsvrgb_scale.sv
// ----------------------------------------------------------------------------
// HSV to RGB scale stage
// Multiplies scaled value by each weight and keeps the floored channel code.
// ----------------------------------------------------------------------------
module hsvrgb_scale #(
  parameter int FRAC_BITS    = hsvrgb_pkg::FRAC_BITS_DEF,
  parameter int CHANNEL_BITS = hsvrgb_pkg::CHANNEL_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  hsvrgb_pkg::sector_t               in_sector,
  input  logic [FRAC_BITS+CHANNEL_BITS-1:0] vscale,
  input  logic [2*FRAC_BITS:0]              wp,
  input  logic [2*FRAC_BITS:0]              wq,
  input  logic [2*FRAC_BITS:0]              wt,
  output logic                              valid,
  output hsvrgb_pkg::sector_t               sector,
  output logic [CHANNEL_BITS-1:0]           cv,
  output logic [CHANNEL_BITS-1:0]           cp,
  output logic [CHANNEL_BITS-1:0]           cq,
  output logic [CHANNEL_BITS-1:0]           ct
);
  import hsvrgb_pkg::*;

  localparam int PW = 3*FRAC_BITS + CHANNEL_BITS + 1;

  logic [PW-1:0] prod_p;
  logic [PW-1:0] prod_q;
  logic [PW-1:0] prod_t;

  assign prod_p = PW'(vscale) * PW'(wp);
  assign prod_q = PW'(vscale) * PW'(wq);
  assign prod_t = PW'(vscale) * PW'(wt);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
  end

  // Drop 3*FRAC_BITS fraction bits; the v weight is exactly one
  always_ff @(posedge clk) begin
    sector <= in_sector;
    cv     <= vscale[FRAC_BITS+CHANNEL_BITS-1:FRAC_BITS];
    cp     <= prod_p[3*FRAC_BITS+CHANNEL_BITS-1:3*FRAC_BITS];
    cq     <= prod_q[3*FRAC_BITS+CHANNEL_BITS-1:3*FRAC_BITS];
    ct     <= prod_t[3*FRAC_BITS+CHANNEL_BITS-1:3*FRAC_BITS];
  end

endmodule

FILE: rtl/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter
// An item passes the prep, weight and scale registers, then the output register, where done rises.
// Throughput: one item per clock; four register stages, no stage iterates.
// busy is held low: the result side cannot stall, so every item flows through.
// Reset clears the stage valid bits and done; data registers are not reset.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter #(
  parameter int FRAC_BITS    = hsvrgb_pkg::FRAC_BITS_DEF,
  parameter int CHANNEL_BITS = hsvrgb_pkg::CHANNEL_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [FRAC_BITS-1:0]    hue,
  input  logic [FRAC_BITS:0]      saturation,
  input  logic [FRAC_BITS:0]      brightness,
  output logic                    done,
  output logic [CHANNEL_BITS-1:0] red,
  output logic [CHANNEL_BITS-1:0] green,
  output logic [CHANNEL_BITS-1:0] blue
);
  import hsvrgb_pkg::*;

  // Stage 1: clamp, hue sector split, value scaling
  logic                              s1_valid;
  logic [FRAC_BITS:0]                s1_sat;
  logic [FRAC_BITS-1:0]              s1_frac;
  sector_t                           s1_sector;
  logic [FRAC_BITS+CHANNEL_BITS-1:0] s1_vscale;

  // Stage 2: weights
  logic                              s2_valid;
  sector_t                           s2_sector;
  logic [FRAC_BITS+CHANNEL_BITS-1:0] s2_vscale;
  logic [2*FRAC_BITS:0]              s2_wp;
  logic [2*FRAC_BITS:0]              s2_wq;
  logic [2*FRAC_BITS:0]              s2_wt;

  // Stage 3: channel codes
  logic                              s3_valid;
  sector_t                           s3_sector;
  logic [CHANNEL_BITS-1:0]           s3_cv;
  logic [CHANNEL_BITS-1:0]           s3_cp;
  logic [CHANNEL_BITS-1:0]           s3_cq;
  logic [CHANNEL_BITS-1:0]           s3_ct;

  // Channel order picked by sector
  logic [CHANNEL_BITS-1:0]           red_next;
  logic [CHANNEL_BITS-1:0]           green_next;
  logic [CHANNEL_BITS-1:0]           blue_next;

  // Every stage advances each cycle, so an item is never refused
  assign busy = 1'b0;

  hsvrgb_prep #(
    .FRAC_BITS    (FRAC_BITS),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_prep (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start & ~busy),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .valid      (s1_valid),
    .sat        (s1_sat),
    .frac       (s1_frac),
    .sector     (s1_sector),
    .vscale     (s1_vscale)
  );

  hsvrgb_weight #(
    .FRAC_BITS    (FRAC_BITS),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_weight (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .sat       (s1_sat),
    .frac      (s1_frac),
    .in_sector (s1_sector),
    .in_vscale (s1_vscale),
    .valid     (s2_valid),
    .sector    (s2_sector),
    .vscale    (s2_vscale),
    .wp        (s2_wp),
    .wq        (s2_wq),
    .wt        (s2_wt)
  );

  hsvrgb_scale #(
    .FRAC_BITS    (FRAC_BITS),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_sector (s2_sector),
    .vscale    (s2_vscale),
    .wp        (s2_wp),
    .wq        (s2_wq),
    .wt        (s2_wt),
    .valid     (s3_valid),
    .sector    (s3_sector),
    .cv        (s3_cv),
    .cp        (s3_cp),
    .cq        (s3_cq),
    .ct        (s3_ct)
  );

  // Route v, p, q, t to red, green and blue. Sector codes above the
  // magenta-to-red sector cannot occur and share its arm.
  always_comb begin
    unique case (s3_sector)
      SEC_R_Y: begin
        red_next   = s3_cv;
        green_next = s3_ct;
        blue_next  = s3_cp;
      end
      SEC_Y_G: begin
        red_next   = s3_cq;
        green_next = s3_cv;
        blue_next  = s3_cp;
      end
      SEC_G_C: begin
        red_next   = s3_cp;
        green_next = s3_cv;
        blue_next  = s3_ct;
      end
      SEC_C_B: begin
        red_next   = s3_cp;
        green_next = s3_cq;
        blue_next  = s3_cv;
      end
      SEC_B_M: begin
        red_next   = s3_ct;
        green_next = s3_cp;
        blue_next  = s3_cv;
      end
      default: begin
        red_next   = s3_cv;
        green_next = s3_cp;
        blue_next  = s3_cq;
      end
    endcase
  end

  // Output register: done marks each item for exactly one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    red   <= red_next;
    green <= green_next;
    blue  <= blue_next;
  end

endmodule
